### sv/ffra_pkg.sv
// Shared types and constants for the first-fit region allocator.
// No dependencies; the top level and the engine import this package.
`timescale 1ns / 1ps

package ffra_pkg;

    // Region table depth and the index and counter widths that follow from it
    localparam int MAX_REGIONS = 16;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(MAX_REGIONS);

    // First address past the 32-bit address space
    localparam logic [32:0] ADDR_TOP = 33'h1_0000_0000;

    // Request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic REG_POOL_BASE   = 1'b0;
    localparam logic REG_POOL_LENGTH = 1'b1;

    typedef struct packed {
        logic [31:0] pool_base;
        logic [31:0] pool_length;
    } t_cfg;

    typedef struct packed {
        logic        action;
        logic [31:0] request_size;
        logic [31:0] request_address;
    } t_req;

    typedef struct packed {
        logic        success;
        logic [31:0] granted_address;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_SCAN,
        ST_CAND_RD,
        ST_CAND_EVAL,
        ST_CAND_CHK,
        ST_COMMIT,
        ST_FSCAN,
        ST_DONE
    } t_state;

endpackage

### sv/first_fit_region_allocator.sv
// First-fit region allocator top level: APB config registers, stream ports,
// output register. Depends on ffra_pkg and ffra_engine.
//
//  Channel  Dir  Handshake             Contents
//  s_axis   in   tvalid/tready         tuser: action; tdata: request_size, request_address
//  m_axis   out  tvalid/tready         tuser: success; tdata: granted_address
//  apb      in   psel/penable/pready   pool_base at 0x0, pool_length at 0x4
//
// An allocate checks candidate starts, the pool start and the held region ends that pass
// the pool and best-so-far filter; each overlap scan reads the table RAM one entry per
// cycle into one comparator. s_axis_tready is high only while the sequencer is idle.
// Reset clears the valid bits at once. A stalled m_axis holds the result while the next
// item is already worked on.
`timescale 1ns / 1ps

module first_fit_region_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] request_size, [63:32] request_address
    input  logic        s_axis_tuser,   // [0] action
    // stream output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] granted_address
    output logic        m_axis_tuser,   // [0] success
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import ffra_pkg::*;

    t_cfg r_cfg, n_cfg;
    t_req req;
    t_rsp rsp;
    t_rsp r_out, n_out;
    logic r_out_vld, n_out_vld;
    logic rsp_valid, rsp_ready, cfg_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_POOL_BASE:   n_cfg.pool_base   = pwdata;
                REG_POOL_LENGTH: n_cfg.pool_length = pwdata;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_POOL_BASE:   prdata = r_cfg.pool_base;
            REG_POOL_LENGTH: prdata = r_cfg.pool_length;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Request unpack
    assign req = '{action:          s_axis_tuser,
                   request_size:    s_axis_tdata[31:0],
                   request_address: s_axis_tdata[63:32]};

    ffra_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    // Output register
    assign rsp_ready = !r_out_vld || m_axis_tready;
    assign n_out_vld = (rsp_valid && rsp_ready) || (r_out_vld && !m_axis_tready);
    assign n_out     = (rsp_valid && rsp_ready) ? rsp : r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out.granted_address;
    assign m_axis_tuser  = r_out.success;

endmodule

### sv/ffra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ffra_engine.sv
// Allocation engine: region table (RAM plus valid bits) and the sequencer
// that runs the first-fit search and the free lookup. Depends on ffra_pkg, ffra_ram.
`timescale 1ns / 1ps

module ffra_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ffra_pkg::t_cfg i_cfg,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ffra_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output ffra_pkg::t_rsp o_rsp
);

    import ffra_pkg::*;

    t_state                 r_state, n_state;
    t_req                   r_req, n_req;
    t_rsp                   r_rsp, n_rsp;
    logic [32:0]            r_lo, n_lo;
    logic [32:0]            r_hi, n_hi;
    logic [32:0]            r_hms, n_hms;
    logic [32:0]            r_pos, n_pos;
    logic [32:0]            r_pos_end, n_pos_end;
    logic [32:0]            r_best, n_best;
    logic                   r_found, n_found;
    logic                   r_cand_pool, n_cand_pool;
    logic [IDX_W-1:0]       r_slot, n_slot;
    logic [CNT_W-1:0]       r_j, n_j;
    logic [CNT_W-1:0]       r_k, n_k;
    logic                   r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx, n_rd_idx;
    logic [MAX_REGIONS-1:0] r_valid, n_valid;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [63:0]      ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [63:0]      ram_rdata;

    logic [32:0]      rs, re, size33, pool_sum, room;
    logic             issue, hit, match, full, cand_ok;
    logic [IDX_W-1:0] free_slot;

    // Region table: start in the low word, length in the high word
    ffra_ram #(
        .WIDTH (64),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = IDX_W'(i);
            end
        end
    end

    assign full = &r_valid;

    // Shared compare unit: entry under scan against the current span
    assign rs     = {1'b0, ram_rdata[31:0]};
    assign re     = rs + {1'b0, ram_rdata[63:32]};
    assign size33 = {1'b0, r_req.request_size};
    assign issue  = (r_k < N_CNT);
    assign hit    = r_rd_vld && r_valid[r_rd_idx] && (r_pos < re) && (rs < r_pos_end);
    assign match  = r_rd_vld && r_valid[r_rd_idx]
                    && (ram_rdata[31:0] == r_req.request_address);

    assign pool_sum = {1'b0, i_cfg.pool_base} + {1'b0, i_cfg.pool_length};
    assign room     = r_hi - r_lo;
    assign cand_ok  = (r_pos >= r_lo) && (r_pos <= r_hms)
                      && !(r_found && (r_pos >= r_best));

    // Sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_rsp       = r_rsp;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_hms       = r_hms;
        n_pos       = r_pos;
        n_pos_end   = r_pos_end;
        n_best      = r_best;
        n_found     = r_found;
        n_cand_pool = r_cand_pool;
        n_slot      = r_slot;
        n_j         = r_j;
        n_k         = r_k;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_valid     = r_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_slot;
        ram_wdata   = {r_req.request_size, r_best[31:0]};
        ram_raddr   = r_k[IDX_W-1:0];
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req = i_req;
                    n_k   = '0;
                    n_state = (i_req.action == ACT_ALLOC) ? ST_PREP : ST_FSCAN;
                end
            end

            // Usable pool, cut at the top of the address space
            ST_PREP: begin
                n_lo    = {1'b0, i_cfg.pool_base};
                n_hi    = (pool_sum > ADDR_TOP) ? ADDR_TOP : pool_sum;
                n_slot  = free_slot;
                n_state = ST_CHECK;
            end

            // Early rejects, then try the pool start as first candidate
            ST_CHECK: begin
                if ((r_req.request_size == '0) || (size33 > room) || full) begin
                    n_rsp   = '{success: 1'b0, granted_address: '0};
                    n_state = ST_DONE;
                end else begin
                    n_hms       = r_hi - size33;
                    n_pos       = r_lo;
                    n_pos_end   = r_lo + size33;
                    n_found     = 1'b0;
                    n_cand_pool = 1'b1;
                    n_j         = '0;
                    n_k         = '0;
                    n_state     = ST_SCAN;
                end
            end

            // Overlap scan, one entry per cycle, each entry read in the cycle before its compare
            ST_SCAN: begin
                if (issue) begin
                    n_k      = r_k + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_k[IDX_W-1:0];
                end
                if (hit) begin
                    n_rd_vld = 1'b0;
                    n_state  = ST_CAND_RD;
                end else if (!issue && !r_rd_vld) begin
                    n_found = 1'b1;
                    n_best  = r_pos;
                    // nothing can beat the pool start
                    n_state = r_cand_pool ? ST_COMMIT : ST_CAND_RD;
                end
            end

            // Next held region whose end is a candidate
            ST_CAND_RD: begin
                n_cand_pool = 1'b0;
                ram_raddr   = r_j[IDX_W-1:0];
                if (r_j == N_CNT) begin
                    if (r_found) begin
                        n_state = ST_COMMIT;
                    end else begin
                        n_rsp   = '{success: 1'b0, granted_address: '0};
                        n_state = ST_DONE;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                    if (r_valid[r_j[IDX_W-1:0]]) begin
                        n_state = ST_CAND_EVAL;
                    end
                end
            end

            ST_CAND_EVAL: begin
                n_pos   = re;
                n_state = ST_CAND_CHK;
            end

            // Candidate must lie in the pool and improve on the best so far
            ST_CAND_CHK: begin
                n_pos_end = r_pos + size33;
                n_k       = '0;
                n_state   = cand_ok ? ST_SCAN : ST_CAND_RD;
            end

            ST_COMMIT: begin
                ram_we          = 1'b1;
                n_valid[r_slot] = 1'b1;
                n_rsp           = '{success: 1'b1, granted_address: r_best[31:0]};
                n_state         = ST_DONE;
            end

            // Free: first held region that starts at the address
            ST_FSCAN: begin
                if (issue) begin
                    n_k      = r_k + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_k[IDX_W-1:0];
                end
                if (match) begin
                    n_rd_vld          = 1'b0;
                    n_valid[r_rd_idx] = 1'b0;
                    n_rsp             = '{success: 1'b1, granted_address: '0};
                    n_state           = ST_DONE;
                end else if (!issue && !r_rd_vld) begin
                    n_rsp   = '{success: 1'b0, granted_address: '0};
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_rd_vld <= n_rd_vld;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_rsp       <= n_rsp;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_hms       <= n_hms;
        r_pos       <= n_pos;
        r_pos_end   <= n_pos_end;
        r_best      <= n_best;
        r_found     <= n_found;
        r_cand_pool <= n_cand_pool;
        r_slot      <= n_slot;
        r_j         <= n_j;
        r_k         <= n_k;
        r_rd_idx    <= n_rd_idx;
    end

    assign o_rsp = r_rsp;

    // The slot being filled is free
    a_commit_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) |-> !r_valid[r_slot])
        else $error("commit into a held slot");

    // A granted region lies inside the usable pool
    a_grant_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) |-> ((r_best >= r_lo) && (r_best + size33 <= r_hi)))
        else $error("granted region outside pool");

    // Pending table reads only occur during a scan
    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ((r_state == ST_SCAN) || (r_state == ST_FSCAN)))
        else $error("table read pending outside a scan");

    // A successful free releases exactly one region
    a_free_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FSCAN && match)
        |=> ($countones(r_valid) + 1 == $countones($past(r_valid))))
        else $error("free did not release exactly one region");

    // Reset empties the table
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_valid == '0))
        else $error("table not empty after reset");

endmodule
